>>> rtl/core/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types and constants for the nearest-seed colour lookup core.
// ----------------------------------------------------------------------------
package nsc_pkg;

  // fixed field widths
  localparam int SLOT_W  = 11;
  localparam int COORD_W = 12;
  localparam int COUNT_W = 12;
  localparam int CHAN_W  = 8;
  localparam int COL_W   = 3 * CHAN_W;
  localparam int DIST_W  = 25;
  localparam int EXT_W   = 17;   // holds any slot count up to 65536

  // parameter defaults
  localparam int NUM_SEEDS_DEF  = 2048;
  localparam int COORD_BITS_DEF = 12;

  localparam logic [COUNT_W-1:0] SEED_COUNT_RST = 12'd1600;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PUSH
  } nsc_state_t;

  // control that travels with each slot read through the distance pipe
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } scan_ctl_t;

endpackage

>>> rtl/core/nsc_if.sv
// ----------------------------------------------------------------------------
// nsc_if
// Valid/ready channels: request words (load or query) and result words.
// ----------------------------------------------------------------------------
interface nsc_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [nsc_pkg::SLOT_W-1:0]    seed_slot;
  logic [nsc_pkg::COORD_W-1:0]   coord_x;
  logic [nsc_pkg::COORD_W-1:0]   coord_y;
  logic [nsc_pkg::CHAN_W-1:0]    seed_red;
  logic [nsc_pkg::CHAN_W-1:0]    seed_green;
  logic [nsc_pkg::CHAN_W-1:0]    seed_blue;

  modport source (output valid, cmd, seed_slot, coord_x, coord_y,
                  seed_red, seed_green, seed_blue, input ready);
  modport sink   (input valid, cmd, seed_slot, coord_x, coord_y,
                  seed_red, seed_green, seed_blue, output ready);
endinterface

interface nsc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [nsc_pkg::CHAN_W-1:0]    red;
  logic [nsc_pkg::CHAN_W-1:0]    green;
  logic [nsc_pkg::CHAN_W-1:0]    blue;
  logic [nsc_pkg::SLOT_W-1:0]    nearest_slot;
  logic [nsc_pkg::DIST_W-1:0]    best_dist_sq;

  modport source (output valid, red, green, blue, nearest_slot, best_dist_sq,
                  input ready);
  modport sink   (input valid, red, green, blue, nearest_slot, best_dist_sq,
                  output ready);
endinterface

>>> rtl/core/nearest_seed_colour_lookup_core.sv
// ----------------------------------------------------------------------------
// nearest_seed_colour_lookup_core
// Brute-force Voronoi lookup: nearest loaded seed to a pixel, with its colour.
// ----------------------------------------------------------------------------
// Usage:
//   req carries load words (cmd = load: write one seed slot with position and
//   colour) and query words (cmd = query: pixel position). rsp returns one word
//   per query: colour, slot and squared distance of the nearest seed among
//   slots 0 .. seed_count-1; ties go to the lowest slot. Loads return nothing.
//   cfg_we/cfg_data write seed_count (0 acts as 1, above NUM_SEEDS saturates).
// Timing:
//   A load writes its seed slot when accepted. A query result reaches the
//   output register after a scan of N slots, N being the effective seed count:
//   the seed table's single read port scans one slot per cycle, followed by
//   the two-stage distance/compare pipe. req.ready is high only between items.
// Reset:
//   Clears control state and sets seed_count to 1600. The seed table is not
//   cleared; every scanned slot must be loaded before it is queried.
// Stall:
//   The result sits in an output register until rsp.ready; meanwhile new
//   words are accepted, and a finished query waits for the register to free.
// ----------------------------------------------------------------------------
module nearest_seed_colour_lookup_core #(
  parameter int NUM_SEEDS  = nsc_pkg::NUM_SEEDS_DEF,
  parameter int COORD_BITS = nsc_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nsc_pkg::COUNT_W-1:0]    cfg_data,
  nsc_req_if.sink                        req,
  nsc_rsp_if.source                      rsp
);

  localparam int AW = (NUM_SEEDS > 1) ? $clog2(NUM_SEEDS) : 1;
  localparam int CW = (COORD_BITS < nsc_pkg::COORD_W) ? COORD_BITS : nsc_pkg::COORD_W;
  localparam int DW = 2 * CW + 1;
  localparam logic [nsc_pkg::EXT_W-1:0] NS_EXT = nsc_pkg::EXT_W'(NUM_SEEDS);

  logic [nsc_pkg::COUNT_W-1:0] seed_count;
  nsc_pkg::nsc_state_t         state, state_next;
  logic [AW-1:0]               scan_idx, scan_idx_next, last_idx;
  logic [CW-1:0]               qx, qy;
  nsc_pkg::scan_ctl_t          issue_ctl, mem_ctl;
  logic [AW-1:0]               mem_idx;
  logic                        accept, is_load, is_query, rd_en, wr_en, out_load;
  logic [nsc_pkg::EXT_W-1:0]   slot_ext, cnt_ext, last_ext, sc_ext;
  logic [2*CW-1:0]             rd_pos;
  logic [nsc_pkg::COL_W-1:0]   rd_col, best_col;
  logic                        dist_done;
  logic [AW-1:0]               best_idx;
  logic [DW-1:0]               best_dist;
  logic [nsc_pkg::EXT_W-1:0]   best_ext;

  // ---- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_count <= nsc_pkg::SEED_COUNT_RST;
    end else if (cfg_we) begin
      seed_count <= cfg_data;
    end
  end

  // ---- request decode
  assign req.ready = (state == nsc_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign is_load   = accept && (req.cmd == nsc_pkg::CMD_LOAD);
  assign is_query  = accept && (req.cmd == nsc_pkg::CMD_QUERY);

  assign slot_ext = nsc_pkg::EXT_W'(req.seed_slot);
  assign wr_en    = is_load && (slot_ext < NS_EXT);

  always_comb begin
    sc_ext = nsc_pkg::EXT_W'(seed_count);
    if (sc_ext == '0) begin
      cnt_ext = nsc_pkg::EXT_W'(1);
    end else if (sc_ext > NS_EXT) begin
      cnt_ext = NS_EXT;
    end else begin
      cnt_ext = sc_ext;
    end
    last_ext = cnt_ext - nsc_pkg::EXT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (is_query) begin
      qx       <= req.coord_x[CW-1:0];
      qy       <= req.coord_y[CW-1:0];
      last_idx <= last_ext[AW-1:0];
    end
  end

  // ---- scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= nsc_pkg::ST_IDLE;
      scan_idx <= '0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
    end
  end

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    rd_en         = 1'b0;
    issue_ctl     = '0;
    out_load      = 1'b0;
    case (state)
      nsc_pkg::ST_IDLE: begin
        scan_idx_next = '0;
        if (is_query) begin
          state_next = nsc_pkg::ST_SCAN;
        end
      end
      nsc_pkg::ST_SCAN: begin
        rd_en           = 1'b1;
        issue_ctl.vld   = 1'b1;
        issue_ctl.first = (scan_idx == '0);
        issue_ctl.last  = (scan_idx == last_idx);
        scan_idx_next   = scan_idx + AW'(1);
        if (scan_idx == last_idx) begin
          state_next = nsc_pkg::ST_DRAIN;
        end
      end
      nsc_pkg::ST_DRAIN: begin
        if (dist_done) begin
          state_next = nsc_pkg::ST_PUSH;
        end
      end
      nsc_pkg::ST_PUSH: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = nsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nsc_pkg::ST_IDLE;
      end
    endcase
  end

  // control aligned with the registered memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_ctl <= '0;
    end else begin
      mem_ctl <= issue_ctl;
    end
  end

  always_ff @(posedge clk) begin
    mem_idx <= scan_idx;
  end

  nsc_seed_mem #(
    .DEPTH (NUM_SEEDS),
    .AW    (AW),
    .PW    (2 * CW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_ext[AW-1:0]),
    .wr_pos  ({req.coord_y[CW-1:0], req.coord_x[CW-1:0]}),
    .wr_col  ({req.seed_red, req.seed_green, req.seed_blue}),
    .rd_en   (rd_en),
    .rd_addr (scan_idx),
    .rd_pos  (rd_pos),
    .rd_col  (rd_col)
  );

  nsc_dist_cmp #(
    .AW (AW),
    .CW (CW),
    .DW (DW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (mem_ctl),
    .idx_in    (mem_idx),
    .qx        (qx),
    .qy        (qy),
    .pos_in    (rd_pos),
    .col_in    (rd_col),
    .done      (dist_done),
    .best_idx  (best_idx),
    .best_dist (best_dist),
    .best_col  (best_col)
  );

  // ---- output register
  assign best_ext = nsc_pkg::EXT_W'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.red          <= best_col[3*nsc_pkg::CHAN_W-1:2*nsc_pkg::CHAN_W];
      rsp.green        <= best_col[2*nsc_pkg::CHAN_W-1:nsc_pkg::CHAN_W];
      rsp.blue         <= best_col[nsc_pkg::CHAN_W-1:0];
      rsp.nearest_slot <= best_ext[nsc_pkg::SLOT_W-1:0];
      rsp.best_dist_sq <= nsc_pkg::DIST_W'(best_dist);
    end
  end

`ifndef SYNTHESIS
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    dist_done |-> (state == nsc_pkg::ST_DRAIN))
    else $error("distance pipe finished outside drain");

  a_query_starts_scan: assert property (@(posedge clk) disable iff (rst)
    is_query |=> (state == nsc_pkg::ST_SCAN) && (scan_idx == '0))
    else $error("query did not start a scan at slot zero");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (best_idx <= last_idx))
    else $error("nearest slot beyond scanned range");
`endif

endmodule

>>> rtl/core/nsc_seed_mem.sv
// ----------------------------------------------------------------------------
// nsc_seed_mem
// Seed table: position and colour arrays, one write and one registered read.
// ----------------------------------------------------------------------------
module nsc_seed_mem #(
  parameter int DEPTH = nsc_pkg::NUM_SEEDS_DEF,
  parameter int AW    = 11,
  parameter int PW    = 24
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [PW-1:0]               wr_pos,
  input  logic [nsc_pkg::COL_W-1:0]   wr_col,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [PW-1:0]               rd_pos,
  output logic [nsc_pkg::COL_W-1:0]   rd_col
);

  logic [PW-1:0]             pos_mem [DEPTH];
  logic [nsc_pkg::COL_W-1:0] col_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= wr_pos;
      col_mem[wr_addr] <= wr_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pos <= pos_mem[rd_addr];
      rd_col <= col_mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/nsc_dist_cmp.sv
// ----------------------------------------------------------------------------
// nsc_dist_cmp
// Squared-distance pipe and running minimum over the scanned slots.
// ----------------------------------------------------------------------------
module nsc_dist_cmp #(
  parameter int AW = 11,
  parameter int CW = 12,
  parameter int DW = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  nsc_pkg::scan_ctl_t          ctl_in,
  input  logic [AW-1:0]               idx_in,
  input  logic [CW-1:0]               qx,
  input  logic [CW-1:0]               qy,
  input  logic [2*CW-1:0]             pos_in,
  input  logic [nsc_pkg::COL_W-1:0]   col_in,
  output logic                        done,
  output logic [AW-1:0]               best_idx,
  output logic [DW-1:0]               best_dist,
  output logic [nsc_pkg::COL_W-1:0]   best_col
);

  logic [CW-1:0]             px, py, dx, dy;
  nsc_pkg::scan_ctl_t        s1_ctl;
  logic [AW-1:0]             s1_idx;
  logic [2*CW-1:0]           s1_sqx, s1_sqy;
  logic [nsc_pkg::COL_W-1:0] s1_col;
  logic [DW-1:0]             sum;

  // position word is {row, column}
  assign px = pos_in[CW-1:0];
  assign py = pos_in[2*CW-1:CW];

  always_comb begin
    dx = (qx >= px) ? qx - px : px - qx;
    dy = (qy >= py) ? qy - py : py - qy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= idx_in;
    s1_sqx <= dx * dx;
    s1_sqy <= dy * dy;
    s1_col <= col_in;
  end

  assign sum = DW'(s1_sqx) + DW'(s1_sqy);

  // strict less-than keeps the lowest slot on ties
  always_ff @(posedge clk) begin
    if (s1_ctl.vld && (s1_ctl.first || sum < best_dist)) begin
      best_dist <= sum;
      best_idx  <= s1_idx;
      best_col  <= s1_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_ctl.vld && s1_ctl.last;
    end
  end

endmodule

>>> tb/tb_nearest_seed_colour_lookup_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_seed_colour_lookup_core
// Self-checking bench for the brute-force nearest-seed colour lookup.
// The bench loads the low seed slots first and keeps seed_count within them,
// so no query ever scans a slot that was never written. A short table of
// hand-picked words follows: seed count extremes, exact ties and the
// corner-to-corner distance. After that come random load/query words under
// several traffic mixes and one long output stall. A shadow copy of the seed
// table predicts each query result that the hand-picked rows do not give, and
// the results are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_nearest_seed_colour_lookup_core;

  localparam int NSEEDS    = nsc_pkg::NUM_SEEDS_DEF;
  localparam int LOADED    = 48;
  localparam int PHASE_LEN = 45;
  localparam int HOLD_LEN  = 400;

  localparam logic [nsc_pkg::COUNT_W-1:0] FULL_CNT = nsc_pkg::COUNT_W'(LOADED);
  localparam logic LD = nsc_pkg::CMD_LOAD;
  localparam logic QY = nsc_pkg::CMD_QUERY;

  typedef struct packed {
    logic                        cmd;
    logic [nsc_pkg::SLOT_W-1:0]  slot;
    logic [nsc_pkg::COORD_W-1:0] x;
    logic [nsc_pkg::COORD_W-1:0] y;
    logic [nsc_pkg::COL_W-1:0]   rgb;
  } seed_word_t;

  typedef struct packed {
    logic [nsc_pkg::COL_W-1:0]  rgb;
    logic [nsc_pkg::SLOT_W-1:0] slot;
    logic [nsc_pkg::DIST_W-1:0] dist_sq;
  } colour_hit_t;

  typedef struct {
    logic [nsc_pkg::COUNT_W-1:0] cnt;
    seed_word_t                  word;
    bit                          typed;
    colour_hit_t                 hit;
  } plan_row_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  logic [nsc_pkg::COUNT_W-1:0] cfg_data;

  nsc_req_if req_ch ();
  nsc_rsp_if rsp_ch ();

  nearest_seed_colour_lookup_core uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always #5 clk = ~clk;

  // shadow seed table and seed_count
  logic [nsc_pkg::COORD_W-1:0] seed_px  [NSEEDS];
  logic [nsc_pkg::COORD_W-1:0] seed_py  [NSEEDS];
  logic [nsc_pkg::COL_W-1:0]   seed_rgb [NSEEDS];
  logic [nsc_pkg::COUNT_W-1:0] live_count;

  colour_hit_t hits_due [$];
  plan_row_t   plan [$];

  int unsigned fails;
  int unsigned n_loads;
  int unsigned n_queries;
  int unsigned n_hits;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  bit          hold_req;

  function automatic int unsigned scan_len(input logic [nsc_pkg::COUNT_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > NSEEDS) return NSEEDS;
    return cnt;
  endfunction

  // first strictly smaller distance wins, so ties stay on the lowest slot
  function automatic colour_hit_t nearest_seed(input logic [nsc_pkg::COORD_W-1:0] px,
                                               input logic [nsc_pkg::COORD_W-1:0] py);
    int unsigned n, best, dx, dy, d, best_d;
    colour_hit_t h;
    n      = scan_len(live_count);
    best   = 0;
    best_d = 0;
    for (int unsigned k = 0; k < n; k++) begin
      dx = (px >= seed_px[k]) ? px - seed_px[k] : seed_px[k] - px;
      dy = (py >= seed_py[k]) ? py - seed_py[k] : seed_py[k] - py;
      d  = dx * dx + dy * dy;
      if (k == 0 || d < best_d) begin
        best_d = d;
        best   = k;
      end
    end
    h.rgb     = seed_rgb[best];
    h.slot    = best[nsc_pkg::SLOT_W-1:0];
    h.dist_sq = (best_d > 32'h1FF_FFFF) ? '1 : best_d[nsc_pkg::DIST_W-1:0];
    return h;
  endfunction

  function automatic seed_word_t random_word();
    seed_word_t  w;
    int unsigned n, pick;
    n     = scan_len(live_count);
    pick  = $urandom_range(n - 1);
    w.cmd  = ($urandom_range(99) < 40) ? nsc_pkg::CMD_LOAD : nsc_pkg::CMD_QUERY;
    w.slot = nsc_pkg::SLOT_W'($urandom_range(NSEEDS - 1));
    w.x    = nsc_pkg::COORD_W'($urandom);
    w.y    = nsc_pkg::COORD_W'($urandom);
    w.rgb  = nsc_pkg::COL_W'($urandom);
    if (w.cmd == nsc_pkg::CMD_LOAD) begin
      if ($urandom_range(4) != 0) w.slot = nsc_pkg::SLOT_W'($urandom_range(n - 1));
      // same position as a live seed: exact tie
      if ($urandom_range(3) == 0) begin
        w.x = seed_px[pick];
        w.y = seed_py[pick];
      end
    end else if ($urandom_range(2) == 0) begin
      // close to a live seed so short distances turn up
      w.x = nsc_pkg::COORD_W'(seed_px[pick] + $urandom_range(8) - 4);
      w.y = nsc_pkg::COORD_W'(seed_py[pick] + $urandom_range(8) - 4);
    end
    return w;
  endfunction

  function automatic void add_row(input logic [nsc_pkg::COUNT_W-1:0] cnt,
                                  input seed_word_t w,
                                  input bit typed, input colour_hit_t h);
    plan_row_t r;
    r.cnt   = cnt;
    r.word  = w;
    r.typed = typed;
    r.hit   = h;
    plan.insert(plan.size(), r);
  endfunction

  // offer one word, hold it until accepted, then update the shadow state
  task automatic send_word(input seed_word_t w, input bit typed, input colour_hit_t h);
    bit offered;
    offered = 1'b0;
    while (!offered) begin
      @(negedge clk);
      if ($urandom_range(99) < src_idle_pct) begin
        req_ch.valid <= 1'b0;
      end else begin
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= w.cmd;
        req_ch.seed_slot  <= w.slot;
        req_ch.coord_x    <= w.x;
        req_ch.coord_y    <= w.y;
        req_ch.seed_red   <= w.rgb[23:16];
        req_ch.seed_green <= w.rgb[15:8];
        req_ch.seed_blue  <= w.rgb[7:0];
        offered = 1'b1;
      end
    end
    do @(posedge clk); while (!req_ch.ready);
    if (w.cmd == nsc_pkg::CMD_LOAD) begin
      seed_px[w.slot]  = w.x;
      seed_py[w.slot]  = w.y;
      seed_rgb[w.slot] = w.rgb;
      n_loads++;
    end else begin
      hits_due.insert(hits_due.size(), typed ? h : nearest_seed(w.x, w.y));
      n_queries++;
    end
  endtask

  // seed_count only changes with the core idle
  task automatic set_seed_count(input logic [nsc_pkg::COUNT_W-1:0] v);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    // a trailing load may still be in flight
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    live_count = v;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    colour_hit_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_hits++;
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got slot %0d dist %0d",
                 $time, rsp_ch.nearest_slot, rsp_ch.best_dist_sq);
        fails++;
      end else begin
        want = hits_due.pop_front();
        check_field("red", want.rgb[23:16], rsp_ch.red);
        check_field("green", want.rgb[15:8], rsp_ch.green);
        check_field("blue", want.rgb[7:0], rsp_ch.blue);
        check_field("nearest_slot", want.slot, rsp_ch.nearest_slot);
        check_field("best_dist_sq", want.dist_sq, rsp_ch.best_dist_sq);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    int unsigned held;
    held         = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && held < HOLD_LEN) begin
        rsp_ch.ready <= 1'b0;
        held++;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    #10ms;
    $display("%0t: timeout, %0d results still outstanding", $time, hits_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned src_mix  [5];
    int unsigned sink_mix [5];
    seed_word_t  w;

    src_mix  = '{0, 64, 0, 8, 0};
    sink_mix = '{0, 0, 64, 8, 0};

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = nsc_pkg::CMD_LOAD;
    req_ch.seed_slot  = '0;
    req_ch.coord_x    = '0;
    req_ch.coord_y    = '0;
    req_ch.seed_red   = '0;
    req_ch.seed_green = '0;
    req_ch.seed_blue  = '0;
    fails             = 0;
    n_loads           = 0;
    n_queries         = 0;
    n_hits            = 0;
    src_idle_pct      = 0;
    sink_stall_pct    = 0;
    hold_req          = 1'b0;
    live_count        = nsc_pkg::SEED_COUNT_RST;

    //    count    cmd slot      x         y         rgb          typed  result
    // zero count scans slot 0 alone
    add_row(12'd0,    {LD, 11'd0,    12'd0,    12'd0,    24'h123456}, 1'b0, '0);
    add_row(12'd0,    {QY, 11'd0,    12'd4095, 12'd4095, 24'h000000}, 1'b1,
            {24'h123456, 11'd0, 25'd33538050});
    add_row(12'd0,    {QY, 11'd0,    12'd0,    12'd0,    24'h000000}, 1'b1,
            {24'h123456, 11'd0, 25'd0});
    add_row(12'd1,    {LD, 11'd0,    12'd4095, 12'd4095, 24'hFFFFFF}, 1'b0, '0);
    add_row(12'd1,    {QY, 11'd0,    12'd0,    12'd0,    24'h000000}, 1'b1,
            {24'hFFFFFF, 11'd0, 25'd33538050});
    // slots 1 and 2 share a position, slot 3 sits two columns right
    add_row(12'd4,    {LD, 11'd1,    12'd100,  12'd100,  24'h010203}, 1'b0, '0);
    add_row(12'd4,    {LD, 11'd2,    12'd100,  12'd100,  24'h040506}, 1'b0, '0);
    add_row(12'd4,    {LD, 11'd3,    12'd102,  12'd100,  24'h070809}, 1'b0, '0);
    add_row(12'd4,    {QY, 11'd0,    12'd101,  12'd100,  24'h000000}, 1'b1,
            {24'h010203, 11'd1, 25'd1});
    add_row(12'd4,    {QY, 11'd0,    12'd102,  12'd100,  24'h000000}, 1'b1,
            {24'h070809, 11'd3, 25'd0});
    add_row(12'd4,    {QY, 11'd2047, 12'd100,  12'd100,  24'hFFFFFF}, 1'b1,
            {24'h010203, 11'd1, 25'd0});
    add_row(12'd4,    {QY, 11'd0,    12'd4095, 12'd4095, 24'h000000}, 1'b1,
            {24'hFFFFFF, 11'd0, 25'd0});
    add_row(12'd4,    {QY, 11'd0,    12'd0,    12'd0,    24'h000000}, 1'b1,
            {24'h010203, 11'd1, 25'd20000});
    add_row(FULL_CNT, {LD, 11'd2047, 12'd3000, 12'd1000, 24'hAABBCC}, 1'b0, '0);
    add_row(FULL_CNT, {QY, 11'd0,    12'd3000, 12'd1000, 24'h000000}, 1'b0, '0);
    add_row(FULL_CNT, {QY, 11'd0,    12'd4095, 12'd4095, 24'h000000}, 1'b0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // the low slots are loaded before any query
    for (int s = 0; s < LOADED; s++) begin
      w.cmd  = nsc_pkg::CMD_LOAD;
      w.slot = nsc_pkg::SLOT_W'(s);
      w.x    = nsc_pkg::COORD_W'($urandom);
      w.y    = nsc_pkg::COORD_W'($urandom);
      w.rgb  = nsc_pkg::COL_W'($urandom);
      send_word(w, 1'b0, '0);
    end

    foreach (plan[i]) begin
      if (plan[i].cnt != live_count) set_seed_count(plan[i].cnt);
      send_word(plan[i].word, plan[i].typed, plan[i].hit);
    end

    for (int p = 0; p < 5; p++) begin
      if (p == 4)
        set_seed_count(nsc_pkg::COUNT_W'($urandom_range(1, 16)));
      else if ($urandom_range(3) == 0)
        set_seed_count(nsc_pkg::COUNT_W'($urandom_range(32, LOADED)));
      else
        set_seed_count(nsc_pkg::COUNT_W'($urandom_range(1, 40)));
      @(posedge clk);
      src_idle_pct   = src_mix[p];
      sink_stall_pct = sink_mix[p];
      // long output stall: the core fills up and backs up its input
      if (p == 4) hold_req = 1'b1;
      for (int i = 0; i < PHASE_LEN; i++) send_word(random_word(), 1'b0, '0);
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d seed loads and %0d pixel queries (%0d results checked),",
             n_loads, n_queries, n_hits);
    $display("seed counts 0 to %0d, exact ties, idle/stall mixes and a %0d-cycle stall.",
             LOADED, HOLD_LEN);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/nsc_pkg.sv
rtl/core/nsc_if.sv
rtl/core/nsc_seed_mem.sv
rtl/core/nsc_dist_cmp.sv
rtl/core/nearest_seed_colour_lookup_core.sv
tb/tb_nearest_seed_colour_lookup_core.sv
